// ===== rtl/vrlp_pkg.sv =====
// Shared types and constants for the video request line parser.
`default_nettype none

package vrlp_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_BAD   = 3'd0;
  localparam kind_t KIND_EMPTY = 3'd1;
  localparam kind_t KIND_GET   = 3'd2;
  localparam kind_t KIND_START = 3'd3;
  localparam kind_t KIND_PAUSE = 3'd4;
  localparam kind_t KIND_END   = 3'd5;
  localparam kind_t KIND_ALIVE = 3'd6;

  localparam int KW_COUNT  = 8;
  localparam int KW_GET    = 0;
  localparam int KW_START  = 1;
  localparam int KW_PAUSE  = 2;
  localparam int KW_END    = 3;
  localparam int KW_ALIVE  = 4;
  localparam int KW_LISTEN = 5;
  localparam int KW_FRAG   = 6;
  localparam int KW_MINUS1 = 7;

  typedef logic [KW_COUNT-1:0] kw_flags_t;

  // Keyword text, first character at index 0, padded with NUL bytes.
  localparam logic [0:15][7:0] KW_TEXT [KW_COUNT] = '{
    {"GET",           {13{8'h00}}},
    {"START",         {11{8'h00}}},
    {"PAUSE",         {11{8'h00}}},
    {"END",           {13{8'h00}}},
    {"ALIVE",         {11{8'h00}}},
    {"LISTEN_PORT",   {5{8'h00}}},
    {"FRAGMENT_SIZE", {3{8'h00}}},
    {"-1",            {14{8'h00}}}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd5, 4'd3, 4'd5, 4'd11, 4'd13, 4'd2
  };

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam logic signed [31:0] IMAGE_ABSENT = -32'sd2;
  localparam logic signed [31:0] VALUE_ABSENT = -32'sd1;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] image_id;
    logic signed [31:0] port_num;
    logic signed [31:0] frag_bytes;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/vrlp_if.sv =====
// Valid/ready channel interfaces for the character input and the request result.
`default_nettype none

interface vrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface vrlp_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        request_kind;
  logic signed [31:0] image_id;
  logic signed [31:0] port_num;
  logic signed [31:0] frag_bytes;

  modport source (output valid, output request_kind, output image_id,
                  output port_num, output frag_bytes, input ready);
  modport sink (input valid, input request_kind, input image_id,
                input port_num, input frag_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/vrlp_scan.sv =====
// Per-byte word scanner: keyword match, number accumulation and word judging.
`default_nettype none

module vrlp_scan #(
  parameter int MAX_WORD = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        char_byte,
  output logic              res_valid,
  output vrlp_pkg::result_t res
);
  import vrlp_pkg::*;

  localparam int LEN_W = $clog2(MAX_WORD + 2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD);

  localparam logic [2:0] POS_KIND   = 3'd0;
  localparam logic [2:0] POS_IMAGE  = 3'd1;
  localparam logic [2:0] POS_LISTEN = 3'd2;
  localparam logic [2:0] POS_PORT   = 3'd3;
  localparam logic [2:0] POS_FRAG   = 3'd4;
  localparam logic [2:0] POS_SIZE   = 3'd5;
  localparam logic [2:0] POS_LAST   = 3'd7;

  logic               in_word_r;
  logic [1:0]         nl_cnt_r;
  logic [2:0]         word_idx_r;
  logic [LEN_W-1:0]   word_len_r;
  kw_flags_t          kw_flags_r;
  logic               digits_r;
  logic [30:0]        num_r;
  kind_t              kind_r;
  logic signed [31:0] image_r;
  logic signed [31:0] port_r;
  logic signed [31:0] frag_r;

  logic               is_nul;
  logic               is_space;
  logic               is_digit;
  logic               word_start;
  logic               is_lf;
  logic [1:0]         nl_cnt_nxt;
  logic               emit;

  logic [LEN_W-1:0]   base_len;
  kw_flags_t          base_flags;
  logic [30:0]        base_num;
  logic [34:0]        num_wide;

  logic [LEN_W-1:0]   word_len_nxt;
  kw_flags_t          kw_flags_nxt;
  logic               digits_nxt;
  logic [30:0]        num_nxt;

  logic               overlong;
  kw_flags_t          kw_hit;
  logic               num_ok;
  logic signed [31:0] num_val;
  kind_t              kind_nxt;
  logic signed [31:0] image_nxt;
  logic signed [31:0] port_nxt;
  logic signed [31:0] frag_nxt;
  kind_t              kind_final;

  assign is_nul     = (char_byte == CH_NUL);
  assign is_space   = (char_byte == CH_SPACE) || (char_byte == CH_LF) ||
                      (char_byte == CH_CR);
  assign is_lf      = (char_byte == CH_LF);
  assign is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign word_start = !in_word_r && !is_space;
  assign nl_cnt_nxt = nl_cnt_r + 2'd1;
  assign emit       = !in_word_r && is_lf && (nl_cnt_nxt == 2'd2);

  // A fresh word starts the character append from the cleared word state.
  assign base_len   = word_start ? '0 : word_len_r;
  assign base_flags = word_start ? '1 : kw_flags_r;
  assign base_num   = word_start ? '0 : num_r;

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_flags_nxt[k] = base_flags[k] && (base_len < LEN_W'(KW_LEN[k])) &&
                        (KW_TEXT[k][base_len[3:0]] == char_byte);
    end
  end

  assign num_wide   = ({4'b0, base_num} << 3) + ({4'b0, base_num} << 1) +
                      {31'b0, char_byte[3:0]};
  assign num_nxt    = !is_digit ? base_num :
                      (num_wide > {4'b0, NUM_MAX}) ? NUM_MAX : num_wide[30:0];
  assign digits_nxt = (word_start || digits_r) && is_digit;
  assign word_len_nxt = (base_len <= LEN_MAX) ? base_len + 1'b1 : base_len;

  // Judge the finished word by its position.
  assign overlong = (word_len_r > LEN_MAX);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_hit[k] = kw_flags_r[k] && (word_len_r == LEN_W'(KW_LEN[k]));
    end
  end

  assign num_ok  = kw_hit[KW_MINUS1] || (digits_r && !overlong);
  assign num_val = kw_hit[KW_MINUS1] ? VALUE_ABSENT : signed'({1'b0, num_r});

  always_comb begin
    kind_nxt  = kind_r;
    image_nxt = image_r;
    port_nxt  = port_r;
    frag_nxt  = frag_r;
    unique case (word_idx_r)
      POS_KIND: begin
        if (kw_hit[KW_GET])        kind_nxt = KIND_GET;
        else if (kw_hit[KW_START]) kind_nxt = KIND_START;
        else if (kw_hit[KW_PAUSE]) kind_nxt = KIND_PAUSE;
        else if (kw_hit[KW_END])   kind_nxt = KIND_END;
        else if (kw_hit[KW_ALIVE]) kind_nxt = KIND_ALIVE;
        else                       kind_nxt = KIND_BAD;
      end
      POS_IMAGE: begin
        if (kind_r != KIND_GET && kind_r != KIND_ALIVE) kind_nxt = KIND_BAD;
        else if (num_ok) image_nxt = num_val;
        else kind_nxt = KIND_BAD;
      end
      POS_LISTEN: begin
        if (!kw_hit[KW_LISTEN]) kind_nxt = KIND_BAD;
      end
      POS_PORT: begin
        if (num_ok) port_nxt = num_val;
        else kind_nxt = KIND_BAD;
      end
      POS_FRAG: begin
        if (kind_r == KIND_ALIVE || !kw_hit[KW_FRAG]) kind_nxt = KIND_BAD;
      end
      POS_SIZE: begin
        if (num_ok) frag_nxt = num_val;
        else kind_nxt = KIND_BAD;
      end
      default: begin
        kind_nxt = KIND_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r  <= 1'b0;
      nl_cnt_r   <= '0;
      word_idx_r <= '0;
      word_len_r <= '0;
      kw_flags_r <= '1;
      digits_r   <= 1'b1;
      num_r      <= '0;
      kind_r     <= KIND_EMPTY;
      image_r    <= IMAGE_ABSENT;
      port_r     <= VALUE_ABSENT;
      frag_r     <= VALUE_ABSENT;
    end else if (byte_valid && !is_nul) begin
      if (in_word_r && is_space) begin
        in_word_r <= 1'b0;
        kind_r    <= kind_nxt;
        image_r   <= image_nxt;
        port_r    <= port_nxt;
        frag_r    <= frag_nxt;
        if (word_idx_r != POS_LAST) word_idx_r <= word_idx_r + 3'd1;
      end else if (!is_space) begin
        in_word_r  <= 1'b1;
        if (word_start) nl_cnt_r <= '0;
        word_len_r <= word_len_nxt;
        kw_flags_r <= kw_flags_nxt;
        digits_r   <= digits_nxt;
        num_r      <= num_nxt;
      end else if (emit) begin
        // Request done: start the next one from scratch.
        nl_cnt_r   <= '0;
        word_idx_r <= '0;
        word_len_r <= '0;
        kw_flags_r <= '1;
        digits_r   <= 1'b1;
        num_r      <= '0;
        kind_r     <= KIND_EMPTY;
        image_r    <= IMAGE_ABSENT;
        port_r     <= VALUE_ABSENT;
        frag_r     <= VALUE_ABSENT;
      end else if (is_lf) begin
        nl_cnt_r <= nl_cnt_nxt;
      end
    end
  end

  assign kind_final = ((kind_r == KIND_GET || kind_r == KIND_ALIVE) &&
                       (image_r == IMAGE_ABSENT)) ? KIND_BAD : kind_r;

  assign res_valid = byte_valid && !is_nul && emit;

  always_comb begin
    res.kind = kind_final;
    if (kind_final == KIND_BAD) begin
      res.image_id   = IMAGE_ABSENT;
      res.port_num   = VALUE_ABSENT;
      res.frag_bytes = VALUE_ABSENT;
    end else begin
      res.image_id   = image_r;
      res.port_num   = port_r;
      res.frag_bytes = frag_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/video_request_line_parser_core.sv =====
// A result beat is registered in the output stage from the LF beat that ends the request.
// Throughput: one character beat per cycle; the input stalls only while a second
// result waits behind a stalled output register.
// Reset: synchronous, active low; clears parser state and the output and skid valid flags.
// No memory clearing pass; the block accepts beats as soon as reset is released.
`default_nettype none

module video_request_line_parser_core #(
  parameter int MAX_WORD = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  vrlp_in_if.sink           in_bus,
  vrlp_out_if.source        out_bus
);
  import vrlp_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res;

  logic    out_v_r;
  result_t out_r;
  logic    skid_v_r;
  result_t skid_r;
  logic    load_out;

  assign in_bus.ready = !skid_v_r;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign load_out     = !out_v_r || out_bus.ready;

  vrlp_scan #(
    .MAX_WORD (MAX_WORD)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_fire),
    .char_byte  (in_bus.char_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (load_out) begin
      // Drain the skid stage first; new results cannot arrive while it is full.
      out_v_r  <= skid_v_r || res_valid;
      skid_v_r <= 1'b0;
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= skid_v_r ? skid_r : res;
    end
    if (!load_out && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.request_kind = out_r.kind;
  assign out_bus.image_id     = out_r.image_id;
  assign out_bus.port_num     = out_r.port_num;
  assign out_bus.frag_bytes   = out_r.frag_bytes;

endmodule

`default_nettype wire

// ===== rtl/vrlp_checker.sv =====
// Port-level assertions for the request line parser, bound to the top level.
`default_nettype none

module vrlp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input vrlp_pkg::kind_t           out_kind,
  input logic signed [31:0]        out_image,
  input logic signed [31:0]        out_port,
  input logic signed [31:0]        out_frag
);
  import vrlp_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_kind) && $stable(out_image) &&
      $stable(out_port) && $stable(out_frag))
    else $error("result beat changed while stalled");

  // Input backpressure only comes from a pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled without a pending result");

  a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BAD |->
      out_image == IMAGE_ABSENT && out_port == VALUE_ABSENT &&
      out_frag == VALUE_ABSENT)
    else $error("bad request carries field values");

  a_image_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_GET || out_kind == KIND_ALIVE) |->
      out_image != IMAGE_ABSENT)
    else $error("get or alive request without image id");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |->
      out_image == IMAGE_ABSENT && out_port == VALUE_ABSENT)
    else $error("empty request carries field values");

endmodule

bind video_request_line_parser_core vrlp_checker u_vrlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_kind  (out_bus.request_kind),
  .out_image (out_bus.image_id),
  .out_port  (out_bus.port_num),
  .out_frag  (out_bus.frag_bytes)
);

`default_nettype wire
